### rtl/core/rsst_pkg.sv
`timescale 1ns / 1ps

package rsst_pkg;

  // One input item: a radius load or a ray trace.
  typedef struct packed {
    logic               req_type;
    logic [4:0]         radius_slot;
    logic [31:0]        radius_value;
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] pos_z;
    logic signed [31:0] dir_x;
    logic signed [31:0] dir_y;
    logic signed [31:0] dir_z;
  } rsst_req_t;

  // One result item: a path segment or an empty path.
  typedef struct packed {
    logic signed [4:0] cell_index;
    logic [31:0]       segment_length;
    logic              path_empty;
    logic              last_segment;
  } rsst_res_t;

  localparam logic REQ_LOAD  = 1'b0;
  localparam logic REQ_TRACE = 1'b1;

  localparam logic signed [4:0] CELL_APPROACH = -5'sd1;

  // Width of the running projection and chord values.
  localparam int unsigned Q_W    = 36;
  localparam int unsigned MUL_W  = 34;
  localparam int unsigned PROD_W = 2 * MUL_W;

  typedef enum logic [4:0] {
    OP_NONE,
    OP_WRRAD,
    OP_LOAD,
    OP_MUL,
    OP_ACC,
    OP_SAVE_R2,
    OP_SAVE_Q,
    OP_SAVE_R,
    OP_P_ZERO,
    OP_P_SQRT,
    OP_SAVE_P,
    OP_SAVE_PP,
    OP_LATCH_RAD,
    OP_CH_ZERO,
    OP_CH_SQRT,
    OP_SAVE_CH,
    OP_EMIT,
    OP_EMIT_MISS
  } rsst_op_e;

  typedef enum logic [3:0] {
    MS_XX,
    MS_YY,
    MS_ZZ,
    MS_XDX,
    MS_YDY,
    MS_ZDZ,
    MS_QQ,
    MS_PP,
    MS_RR
  } rsst_msel_e;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_MUL,
    ST_ACC,
    ST_R2_SAVE,
    ST_Q_SAVE,
    ST_R_WAIT,
    ST_QQ_MUL,
    ST_P_START,
    ST_P_WAIT,
    ST_PP_MUL,
    ST_PP_SAVE,
    ST_CLASS,
    ST_APP_EMIT,
    ST_LOC_R,
    ST_IN_CHK,
    ST_LOC_P,
    ST_IN_LOOP,
    ST_OUT_EMIT,
    ST_CH_RD,
    ST_CH_MUL,
    ST_CH_CHK,
    ST_CH_WAIT
  } rsst_state_e;

  // Command from the controller to the datapath.
  typedef struct packed {
    rsst_op_e          op;
    rsst_msel_e        msel;
    logic              neg;
    logic              last;
    logic signed [4:0] seg_cell;
  } rsst_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic sq_busy;
    logic absq_ge_r;
    logic q_pos;
    logic q_neg;
    logic r_gt_rd;
    logic p_gt_rd;
    logic rd_le_r;
    logic rd_le_p;
    logic rad_le_p;
  } rsst_stat_t;

endpackage

### rtl/core/ray_shell_segment_tracer.sv
`timescale 1ns / 1ps

// Channel     Ports                               Transfer
// request     start, busy, req_i                  start high while busy low
// result      res_strobe_o, res_o                 one cycle per result, no stall
// config      cfg_valid_i, cfg_ready_o, cfg_data_i valid and ready both high
//
// A radius load writes an in-range slot of the radius table and yields no
// result. A trace spends its setup mostly in up to two square roots, then a
// chord step per segment, each dominated by the bit-serial square root unit,
// plus up to two linear shell searches over the shell_count radii.
// Reset clears the controller and sets shell_count to 16; the radius table
// holds no reset value. Results cannot be stalled by the receiver.
module ray_shell_segment_tracer #(
  parameter int unsigned MAX_SHELLS = 16
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start,
  output logic                busy,
  input  rsst_pkg::rsst_req_t req_i,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [4:0]          cfg_data_i,
  output logic                res_strobe_o,
  output rsst_pkg::rsst_res_t res_o
);

  localparam int unsigned IDX_W = $clog2(MAX_SHELLS + 1);

  rsst_pkg::rsst_cmd_t  cmd;
  rsst_pkg::rsst_stat_t stat;
  logic [IDX_W-1:0]     rd_addr;

  rsst_ctrl #(
    .MAX_SHELLS (MAX_SHELLS),
    .IDX_W      (IDX_W)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start       (start),
    .busy        (busy),
    .req_i       (req_i),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_data_i  (cfg_data_i),
    .stat_i      (stat),
    .cmd_o       (cmd),
    .rd_addr_o   (rd_addr)
  );

  rsst_datapath #(
    .MAX_SHELLS (MAX_SHELLS),
    .IDX_W      (IDX_W)
  ) u_datapath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .req_i        (req_i),
    .cmd_i        (cmd),
    .rd_addr_i    (rd_addr),
    .stat_o       (stat),
    .res_strobe_o (res_strobe_o),
    .res_o        (res_o)
  );

  // Every segment needs a chord step, so results never come back to back.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_strobe_o |=> !res_strobe_o)
    else $error("results on consecutive cycles");

  // An accepted trace keeps the block busy on the next cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy && req_i.req_type == rsst_pkg::REQ_TRACE) |=> busy)
    else $error("trace accepted without going busy");

  // An empty path is a single final result with no length.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_strobe_o && res_o.path_empty) |->
      (res_o.last_segment && res_o.segment_length == '0 && res_o.cell_index == '0))
    else $error("malformed empty path result");

endmodule

### rtl/core/rsst_isqrt.sv
`timescale 1ns / 1ps

// Floor square root of a 64-bit value, one result bit per cycle.
module rsst_isqrt (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [63:0] value_i,
  output logic        busy_o,
  output logic [31:0] root_o
);

  logic [63:0] rem_q, rem_d;
  logic [63:0] res_q, res_d;
  logic [63:0] bit_q, bit_d;
  logic [64:0] trial;

  assign trial = {1'b0, res_q} + {1'b0, bit_q};

  // One restoring step per cycle while the probe bit is nonzero.
  always_comb begin
    rem_d = rem_q;
    res_d = res_q;
    bit_d = bit_q;
    if (start_i) begin
      rem_d = value_i;
      res_d = '0;
      bit_d = 64'd1 << 62;
    end else if (bit_q != '0) begin
      if ({1'b0, rem_q} >= trial) begin
        rem_d = rem_q - trial[63:0];
        res_d = (res_q >> 1) + bit_q;
      end else begin
        res_d = res_q >> 1;
      end
      bit_d = bit_q >> 2;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bit_q <= '0;
    end else begin
      bit_q <= bit_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    res_q <= res_d;
  end

  assign busy_o = (bit_q != '0);
  assign root_o = res_q[31:0];

endmodule

### rtl/core/rsst_datapath.sv
`timescale 1ns / 1ps

// Radius table, shared multiplier, square root unit and result register.
module rsst_datapath #(
  parameter int unsigned MAX_SHELLS = 16,
  parameter int unsigned IDX_W      = $clog2(MAX_SHELLS + 1)
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  rsst_pkg::rsst_req_t  req_i,
  input  rsst_pkg::rsst_cmd_t  cmd_i,
  input  logic [IDX_W-1:0]     rd_addr_i,
  output rsst_pkg::rsst_stat_t stat_o,
  output logic                 res_strobe_o,
  output rsst_pkg::rsst_res_t  res_o
);

  localparam int unsigned QW = rsst_pkg::Q_W;
  localparam int unsigned MW = rsst_pkg::MUL_W;
  localparam int unsigned PW = rsst_pkg::PROD_W;

  logic [31:0] radii_q [MAX_SHELLS+1];

  logic signed [31:0] x_q, y_q, z_q, dx_q, dy_q, dz_q;
  logic signed [PW-1:0] prod_q, acc_q;
  logic [63:0] r2_q, pp_q;
  logic [31:0] r_q, p_q, rad_q, rd_data;
  logic signed [QW-1:0] q_q, qn_q, absq;
  logic signed [MW-1:0] mul_a, mul_b;
  logic signed [PW-1:0] acc_shift;
  logic signed [QW:0] ds;
  logic [31:0] len;
  logic sq_start, sq_busy;
  logic [63:0] sq_in;
  logic [31:0] root;
  logic strobe_q;
  rsst_pkg::rsst_res_t res_q;

  assign rd_data = radii_q[rd_addr_i];
  assign absq    = q_q[QW-1] ? -q_q : q_q;

  // Operand selection for the shared multiplier.
  always_comb begin
    case (cmd_i.msel)
      rsst_pkg::MS_XX:  begin mul_a = MW'(x_q);  mul_b = MW'(x_q);  end
      rsst_pkg::MS_YY:  begin mul_a = MW'(y_q);  mul_b = MW'(y_q);  end
      rsst_pkg::MS_ZZ:  begin mul_a = MW'(z_q);  mul_b = MW'(z_q);  end
      rsst_pkg::MS_XDX: begin mul_a = MW'(x_q);  mul_b = MW'(dx_q); end
      rsst_pkg::MS_YDY: begin mul_a = MW'(y_q);  mul_b = MW'(dy_q); end
      rsst_pkg::MS_ZDZ: begin mul_a = MW'(z_q);  mul_b = MW'(dz_q); end
      rsst_pkg::MS_QQ:  begin mul_a = absq[MW-1:0]; mul_b = absq[MW-1:0]; end
      rsst_pkg::MS_PP:  begin
        mul_a = $signed({2'b00, p_q});
        mul_b = $signed({2'b00, p_q});
      end
      rsst_pkg::MS_RR:  begin
        mul_a = $signed({2'b00, rad_q});
        mul_b = $signed({2'b00, rad_q});
      end
      default: begin mul_a = '0; mul_b = '0; end
    endcase
  end

  // Square root operand: start radius, impact distance or chord term.
  always_comb begin
    sq_start = 1'b0;
    sq_in    = '0;
    case (cmd_i.op)
      rsst_pkg::OP_SAVE_R2: begin sq_start = 1'b1; sq_in = acc_q[63:0];           end
      rsst_pkg::OP_P_SQRT:  begin sq_start = 1'b1; sq_in = r2_q - prod_q[63:0];   end
      rsst_pkg::OP_CH_SQRT: begin sq_start = 1'b1; sq_in = prod_q[63:0] - pp_q;   end
      default: ;
    endcase
  end

  rsst_isqrt u_isqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (sq_start),
    .value_i (sq_in),
    .busy_o  (sq_busy),
    .root_o  (root)
  );

  // Segment length saturates to the unsigned 32-bit range.
  assign acc_shift = acc_q >>> 30;
  assign ds = (QW+1)'(qn_q) - (QW+1)'(q_q);
  always_comb begin
    if (ds[QW]) begin
      len = '0;
    end else if (ds[QW-1:32] != '0) begin
      len = '1;
    end else begin
      len = ds[31:0];
    end
  end

  // Working registers and the radius table, written according to the command.
  always_ff @(posedge clk_i) begin
    case (cmd_i.op)
      rsst_pkg::OP_WRRAD: radii_q[IDX_W'(req_i.radius_slot)] <= req_i.radius_value;
      rsst_pkg::OP_LOAD: begin
        x_q   <= req_i.pos_x;
        y_q   <= req_i.pos_y;
        z_q   <= req_i.pos_z;
        dx_q  <= req_i.dir_x;
        dy_q  <= req_i.dir_y;
        dz_q  <= req_i.dir_z;
        acc_q <= '0;
      end
      rsst_pkg::OP_MUL:      prod_q <= mul_a * mul_b;
      rsst_pkg::OP_ACC:      acc_q  <= acc_q + prod_q;
      rsst_pkg::OP_SAVE_R2: begin
        r2_q  <= acc_q[63:0];
        acc_q <= '0;
      end
      rsst_pkg::OP_SAVE_Q:   q_q    <= acc_shift[QW-1:0];
      rsst_pkg::OP_SAVE_R:   r_q    <= root;
      rsst_pkg::OP_P_ZERO:   p_q    <= '0;
      rsst_pkg::OP_SAVE_P:   p_q    <= root;
      rsst_pkg::OP_SAVE_PP:  pp_q   <= prod_q[63:0];
      rsst_pkg::OP_LATCH_RAD: rad_q <= rd_data;
      rsst_pkg::OP_CH_ZERO:  qn_q   <= '0;
      rsst_pkg::OP_SAVE_CH: begin
        qn_q <= cmd_i.neg ? -$signed({4'b0, root}) : $signed({4'b0, root});
      end
      rsst_pkg::OP_EMIT: begin
        res_q.cell_index     <= cmd_i.seg_cell;
        res_q.segment_length <= len;
        res_q.path_empty     <= 1'b0;
        res_q.last_segment   <= cmd_i.last;
        q_q                  <= qn_q;
      end
      rsst_pkg::OP_EMIT_MISS: begin
        res_q.cell_index     <= '0;
        res_q.segment_length <= '0;
        res_q.path_empty     <= 1'b1;
        res_q.last_segment   <= 1'b1;
      end
      default: ;
    endcase
  end

  // Result strobe lasts one cycle per emitted item.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      strobe_q <= 1'b0;
    end else begin
      strobe_q <= (cmd_i.op == rsst_pkg::OP_EMIT) || (cmd_i.op == rsst_pkg::OP_EMIT_MISS);
    end
  end

  assign res_strobe_o = strobe_q;
  assign res_o        = res_q;

  assign stat_o.sq_busy   = sq_busy;
  assign stat_o.absq_ge_r = absq >= $signed({4'b0, r_q});
  assign stat_o.q_pos     = q_q > 0;
  assign stat_o.q_neg     = q_q < 0;
  assign stat_o.r_gt_rd   = r_q > rd_data;
  assign stat_o.p_gt_rd   = p_q > rd_data;
  assign stat_o.rd_le_r   = rd_data <= r_q;
  assign stat_o.rd_le_p   = rd_data <= p_q;
  assign stat_o.rad_le_p  = rad_q <= p_q;

endmodule

### rtl/core/rsst_ctrl.sv
`timescale 1ns / 1ps

// Sequencer: setup arithmetic, shell searches, chord calls and emission.
module rsst_ctrl #(
  parameter int unsigned MAX_SHELLS = 16,
  parameter int unsigned IDX_W      = $clog2(MAX_SHELLS + 1)
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start,
  output logic                 busy,
  input  rsst_pkg::rsst_req_t  req_i,
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic [4:0]           cfg_data_i,
  input  rsst_pkg::rsst_stat_t stat_i,
  output rsst_pkg::rsst_cmd_t  cmd_o,
  output logic [IDX_W-1:0]     rd_addr_o
);

  rsst_pkg::rsst_state_e state_q, state_d, ret_q, ret_d;
  logic [4:0] cfg_q;
  logic [IDX_W-1:0] n_q, n_d, i_q, i_d, j_q, j_d, loc_q, loc_d, imin_q, imin_d;
  logic [IDX_W-1:0] ch_addr_q, ch_addr_d, n_eff;
  logic ch_neg_q, ch_neg_d;
  logic [2:0] m_q, m_d;
  logic out_last;

  // Shell count clamped to 1 .. MAX_SHELLS.
  always_comb begin
    if (cfg_q == '0) begin
      n_eff = IDX_W'(1);
    end else if (cfg_q > 5'(MAX_SHELLS)) begin
      n_eff = IDX_W'(MAX_SHELLS);
    end else begin
      n_eff = IDX_W'(cfg_q);
    end
  end

  assign busy        = (state_q != rsst_pkg::ST_IDLE);
  assign cfg_ready_o = 1'b1;
  assign out_last    = ((i_q + IDX_W'(1)) >= n_q);

  always_comb begin
    state_d   = state_q;
    ret_d     = ret_q;
    n_d       = n_q;
    i_d       = i_q;
    j_d       = j_q;
    loc_d     = loc_q;
    imin_d    = imin_q;
    ch_addr_d = ch_addr_q;
    ch_neg_d  = ch_neg_q;
    m_d       = m_q;
    rd_addr_o = n_q;
    cmd_o.op       = rsst_pkg::OP_NONE;
    cmd_o.msel     = rsst_pkg::MS_XX;
    cmd_o.neg      = ch_neg_q;
    cmd_o.last     = 1'b0;
    cmd_o.seg_cell = 5'(i_q);
    case (state_q)
      rsst_pkg::ST_IDLE: begin
        if (start) begin
          if (req_i.req_type == rsst_pkg::REQ_TRACE) begin
            cmd_o.op = rsst_pkg::OP_LOAD;
            n_d      = n_eff;
            m_d      = '0;
            state_d  = rsst_pkg::ST_MUL;
          end else if (req_i.radius_slot <= 5'(MAX_SHELLS)) begin
            cmd_o.op = rsst_pkg::OP_WRRAD;
          end
        end
      end
      // Three squares, then three direction products, one at a time.
      rsst_pkg::ST_MUL: begin
        cmd_o.op = rsst_pkg::OP_MUL;
        case (m_q)
          3'd0:    cmd_o.msel = rsst_pkg::MS_XX;
          3'd1:    cmd_o.msel = rsst_pkg::MS_YY;
          3'd2:    cmd_o.msel = rsst_pkg::MS_ZZ;
          3'd3:    cmd_o.msel = rsst_pkg::MS_XDX;
          3'd4:    cmd_o.msel = rsst_pkg::MS_YDY;
          default: cmd_o.msel = rsst_pkg::MS_ZDZ;
        endcase
        state_d = rsst_pkg::ST_ACC;
      end
      rsst_pkg::ST_ACC: begin
        cmd_o.op = rsst_pkg::OP_ACC;
        m_d      = m_q + 3'd1;
        if (m_q == 3'd2) begin
          state_d = rsst_pkg::ST_R2_SAVE;
        end else if (m_q == 3'd5) begin
          state_d = rsst_pkg::ST_Q_SAVE;
        end else begin
          state_d = rsst_pkg::ST_MUL;
        end
      end
      rsst_pkg::ST_R2_SAVE: begin
        cmd_o.op = rsst_pkg::OP_SAVE_R2;
        state_d  = rsst_pkg::ST_MUL;
      end
      rsst_pkg::ST_Q_SAVE: begin
        cmd_o.op = rsst_pkg::OP_SAVE_Q;
        state_d  = rsst_pkg::ST_R_WAIT;
      end
      rsst_pkg::ST_R_WAIT: begin
        if (!stat_i.sq_busy) begin
          cmd_o.op = rsst_pkg::OP_SAVE_R;
          state_d  = rsst_pkg::ST_QQ_MUL;
        end
      end
      rsst_pkg::ST_QQ_MUL: begin
        cmd_o.op   = rsst_pkg::OP_MUL;
        cmd_o.msel = rsst_pkg::MS_QQ;
        state_d    = rsst_pkg::ST_P_START;
      end
      rsst_pkg::ST_P_START: begin
        if (stat_i.absq_ge_r) begin
          cmd_o.op = rsst_pkg::OP_P_ZERO;
          state_d  = rsst_pkg::ST_PP_MUL;
        end else begin
          cmd_o.op = rsst_pkg::OP_P_SQRT;
          state_d  = rsst_pkg::ST_P_WAIT;
        end
      end
      rsst_pkg::ST_P_WAIT: begin
        if (!stat_i.sq_busy) begin
          cmd_o.op = rsst_pkg::OP_SAVE_P;
          state_d  = rsst_pkg::ST_PP_MUL;
        end
      end
      rsst_pkg::ST_PP_MUL: begin
        cmd_o.op   = rsst_pkg::OP_MUL;
        cmd_o.msel = rsst_pkg::MS_PP;
        state_d    = rsst_pkg::ST_PP_SAVE;
      end
      rsst_pkg::ST_PP_SAVE: begin
        cmd_o.op = rsst_pkg::OP_SAVE_PP;
        state_d  = rsst_pkg::ST_CLASS;
      end
      // Outer radius on the read port: miss, approach from outside, or start inside.
      rsst_pkg::ST_CLASS: begin
        rd_addr_o = n_q;
        if (stat_i.r_gt_rd) begin
          if (stat_i.q_pos || stat_i.p_gt_rd) begin
            cmd_o.op = rsst_pkg::OP_EMIT_MISS;
            state_d  = rsst_pkg::ST_IDLE;
          end else begin
            ch_addr_d = n_q;
            ch_neg_d  = 1'b1;
            ret_d     = rsst_pkg::ST_APP_EMIT;
            state_d   = rsst_pkg::ST_CH_RD;
          end
        end else begin
          j_d     = IDX_W'(1);
          loc_d   = '0;
          state_d = rsst_pkg::ST_LOC_R;
        end
      end
      rsst_pkg::ST_APP_EMIT: begin
        cmd_o.op       = rsst_pkg::OP_EMIT;
        cmd_o.seg_cell = rsst_pkg::CELL_APPROACH;
        i_d            = n_q - IDX_W'(1);
        state_d        = rsst_pkg::ST_IN_CHK;
      end
      // Linear search for the shell holding the start radius.
      rsst_pkg::ST_LOC_R: begin
        rd_addr_o = j_q;
        if (j_q >= n_q) begin
          i_d     = loc_q;
          state_d = rsst_pkg::ST_IN_CHK;
        end else begin
          if (stat_i.rd_le_r) begin
            loc_d = j_q;
          end
          j_d = j_q + IDX_W'(1);
        end
      end
      rsst_pkg::ST_IN_CHK: begin
        if (stat_i.q_neg) begin
          j_d     = IDX_W'(1);
          loc_d   = '0;
          state_d = rsst_pkg::ST_LOC_P;
        end else begin
          ch_addr_d = i_q + IDX_W'(1);
          ch_neg_d  = 1'b0;
          ret_d     = rsst_pkg::ST_OUT_EMIT;
          state_d   = rsst_pkg::ST_CH_RD;
        end
      end
      // Linear search for the shell holding the impact distance.
      rsst_pkg::ST_LOC_P: begin
        rd_addr_o = j_q;
        if (j_q >= n_q) begin
          imin_d    = loc_q;
          ch_addr_d = i_q;
          ch_neg_d  = 1'b1;
          ret_d     = rsst_pkg::ST_IN_LOOP;
          state_d   = rsst_pkg::ST_CH_RD;
        end else begin
          if (stat_i.rd_le_p) begin
            loc_d = j_q;
          end
          j_d = j_q + IDX_W'(1);
        end
      end
      rsst_pkg::ST_IN_LOOP: begin
        if (i_q > imin_q) begin
          cmd_o.op  = rsst_pkg::OP_EMIT;
          i_d       = i_q - IDX_W'(1);
          ch_addr_d = i_q - IDX_W'(1);
          ch_neg_d  = 1'b1;
          ret_d     = rsst_pkg::ST_IN_LOOP;
        end else begin
          ch_addr_d = i_q + IDX_W'(1);
          ch_neg_d  = 1'b0;
          ret_d     = rsst_pkg::ST_OUT_EMIT;
        end
        state_d = rsst_pkg::ST_CH_RD;
      end
      rsst_pkg::ST_OUT_EMIT: begin
        cmd_o.op   = rsst_pkg::OP_EMIT;
        cmd_o.last = out_last;
        if (out_last) begin
          state_d = rsst_pkg::ST_IDLE;
        end else begin
          i_d       = i_q + IDX_W'(1);
          ch_addr_d = i_q + IDX_W'(2);
          ch_neg_d  = 1'b0;
          ret_d     = rsst_pkg::ST_OUT_EMIT;
          state_d   = rsst_pkg::ST_CH_RD;
        end
      end
      // Chord term of one radius against the impact distance.
      rsst_pkg::ST_CH_RD: begin
        rd_addr_o = ch_addr_q;
        cmd_o.op  = rsst_pkg::OP_LATCH_RAD;
        state_d   = rsst_pkg::ST_CH_MUL;
      end
      rsst_pkg::ST_CH_MUL: begin
        cmd_o.op   = rsst_pkg::OP_MUL;
        cmd_o.msel = rsst_pkg::MS_RR;
        state_d    = rsst_pkg::ST_CH_CHK;
      end
      rsst_pkg::ST_CH_CHK: begin
        if (stat_i.rad_le_p) begin
          cmd_o.op = rsst_pkg::OP_CH_ZERO;
          state_d  = ret_q;
        end else begin
          cmd_o.op = rsst_pkg::OP_CH_SQRT;
          state_d  = rsst_pkg::ST_CH_WAIT;
        end
      end
      rsst_pkg::ST_CH_WAIT: begin
        if (!stat_i.sq_busy) begin
          cmd_o.op = rsst_pkg::OP_SAVE_CH;
          state_d  = ret_q;
        end
      end
      default: state_d = rsst_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= rsst_pkg::ST_IDLE;
      ret_q     <= rsst_pkg::ST_IDLE;
      cfg_q     <= 5'd16;
      n_q       <= '0;
      i_q       <= '0;
      j_q       <= '0;
      loc_q     <= '0;
      imin_q    <= '0;
      ch_addr_q <= '0;
      ch_neg_q  <= 1'b0;
      m_q       <= '0;
    end else begin
      state_q   <= state_d;
      ret_q     <= ret_d;
      n_q       <= n_d;
      i_q       <= i_d;
      j_q       <= j_d;
      loc_q     <= loc_d;
      imin_q    <= imin_d;
      ch_addr_q <= ch_addr_d;
      ch_neg_q  <= ch_neg_d;
      m_q       <= m_d;
      if (cfg_valid_i && cfg_ready_o) begin
        cfg_q <= cfg_data_i;
      end
    end
  end

endmodule
